// ===== rtl/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared constants and codes for the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int HEAP_BYTES_DEF   = 4096;
  localparam int MIN_BLOCK_DEF    = 16;
  localparam int HEADER_BYTES_DEF = 5;

  // fixed widths of the transaction fields
  localparam int FIELD_W  = 13;
  localparam int STATUS_W = 2;

  localparam logic [FIELD_W-1:0] LIMIT_RESET = 13'd4096;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOROOM  = 2'd1,
    ST_CORRUPT = 2'd2,
    ST_IGNORED = 2'd3
  } status_t;

endpackage

// ===== rtl/first_fit_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator over a byte arena with headers kept by byte offset.
// ----------------------------------------------------------------------------
// After reset the header store is swept clear, one entry a cycle; no
// transaction is taken until the sweep ends (limit writes are taken as
// ever). An allocation walks the headers from offset zero, then passes
// the split step, and a mark step too when the chosen block is split,
// before the finish step; the very first allocation goes straight to the
// split step, and a refused allocation skips it. A free reads its header,
// then merges each following free block in turn; a refused free goes to
// the finish step at once, or after the header read when its header turns
// out empty. Each visited header costs one read on the single read port
// of the header memory. A finished result sits in the output register
// until taken; a new request is held off while the block works, and also
// while a result waits for the output register to free up.
module first_fit_heap_allocator #(
  parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
  parameter int MIN_BLOCK    = ffha_pkg::MIN_BLOCK_DEF,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ffha_pkg::FIELD_W-1:0]        cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                op,
  input  logic [ffha_pkg::FIELD_W-1:0]        request_bytes,
  input  logic [ffha_pkg::FIELD_W-1:0]        payload_offset,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ffha_pkg::FIELD_W-1:0]        result_offset,
  output logic [ffha_pkg::STATUS_W-1:0]       status
);

  localparam int AW  = $clog2(HEAP_BYTES);
  localparam int PW0 = (AW + 1 > ffha_pkg::FIELD_W) ? AW + 1 : ffha_pkg::FIELD_W;
  localparam int PW  = PW0 + 1;
  localparam int DW  = PW + 1;

  localparam logic [PW-1:0] HEAP_W = PW'(HEAP_BYTES);
  localparam logic [PW-1:0] MIN_W  = PW'(MIN_BLOCK);
  localparam logic [PW-1:0] HDR_W  = PW'(HEADER_BYTES);
  localparam logic [AW-1:0] CLR_LAST = AW'(HEAP_BYTES - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_WALK, S_FHEAD, S_FMERGE, S_SPLIT, S_MARK, S_FIN
  } state_t;

  state_t                       state;
  logic [ffha_pkg::FIELD_W-1:0] heap_limit;
  logic [PW-1:0]                heap_end;
  logic                         heap_started;
  logic [PW-1:0]                pos;
  logic [PW-1:0]                need;
  logic [PW-1:0]                cur_size;
  logic [PW-1:0]                nxt;
  logic [AW-1:0]                clr_addr;
  logic [ffha_pkg::FIELD_W-1:0] res_offset;
  ffha_pkg::status_t            res_status;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [DW-1:0] rd_data;

  logic          rd_used;
  logic [PW-1:0] rd_size;
  logic [PW-1:0] lim;
  logic [PW-1:0] need_in;
  logic [PW-1:0] req_hdr;
  logic [PW-1:0] off_w;
  logic [PW-1:0] at_w;
  logic [PW-1:0] npos;
  logic [PW:0]   end_sum;
  logic [PW-1:0] rest;
  logic          do_split;
  logic [PW-1:0] split_pos;
  logic [PW-1:0] nxt_merge;
  logic          merge_ok;
  logic [PW-1:0] grant_off;
  logic          accept;
  logic          free_bad;

  ffha_hdr_ram #(
    .DEPTH (HEAP_BYTES),
    .DW    (DW)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);

  assign rd_used = rd_data[DW-1];
  assign rd_size = rd_data[PW-1:0];

  assign lim = ({1'b0, heap_limit} < HEAP_W) ? PW'(heap_limit) : HEAP_W;

  assign req_hdr = PW'(request_bytes) + HDR_W;
  assign need_in = (req_hdr < MIN_W) ? MIN_W : req_hdr;

  assign off_w    = PW'(payload_offset);
  assign at_w     = off_w - HDR_W;
  assign free_bad = !heap_started || (off_w == '0) || (off_w < HDR_W) ||
                    (off_w > heap_end) || (at_w >= HEAP_W);

  // walk step: next header position and the end it would give on append
  assign npos    = pos + rd_size;
  assign end_sum = {1'b0, npos} + {1'b0, need};

  assign rest      = cur_size - need;
  assign split_pos = pos + need;
  assign do_split  = (rest >= MIN_W) && (split_pos < HEAP_W);

  assign nxt_merge = nxt + rd_size;
  assign merge_ok  = (nxt < heap_end) && (nxt < HEAP_W) && !rd_used && (rd_size != '0);

  assign grant_off = pos + HDR_W;

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos[AW-1:0];
    mem_wdata = {1'b1, cur_size};
    mem_raddr = '0;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      S_IDLE: begin
        mem_raddr = (op == ffha_pkg::OP_FREE) ? at_w[AW-1:0] : '0;
      end
      S_WALK: begin
        mem_raddr = npos[AW-1:0];
      end
      S_FHEAD: begin
        mem_raddr = npos[AW-1:0];
      end
      S_FMERGE: begin
        mem_raddr = nxt_merge[AW-1:0];
        if (!merge_ok) begin
          mem_we    = 1'b1;
          mem_wdata = {1'b0, cur_size};
        end
      end
      S_SPLIT: begin
        mem_we = 1'b1;
        if (do_split) begin
          mem_waddr = split_pos[AW-1:0];
          mem_wdata = {1'b0, rest};
        end
      end
      S_MARK: begin
        mem_we    = 1'b1;
        mem_wdata = {1'b1, need};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      heap_limit   <= ffha_pkg::LIMIT_RESET;
      heap_end     <= '0;
      heap_started <= 1'b0;
      clr_addr     <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        heap_limit <= cfg_wdata;
      end
      // the finish step sets out_valid itself
      if (out_valid && !out_stall && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == CLR_LAST) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (accept) begin
            res_offset <= '0;
            need       <= need_in;
            if (op == ffha_pkg::OP_ALLOC) begin
              pos <= '0;
              if (!heap_started) begin
                if (need_in > lim) begin
                  res_status <= ffha_pkg::ST_NOROOM;
                  state      <= S_FIN;
                end else begin
                  // first block: exactly the block size, marked by the split step
                  heap_started <= 1'b1;
                  heap_end     <= need_in;
                  cur_size     <= need_in;
                  state        <= S_SPLIT;
                end
              end else begin
                state <= S_WALK;
              end
            end else if (free_bad) begin
              res_status <= ffha_pkg::ST_IGNORED;
              state      <= S_FIN;
            end else begin
              pos   <= at_w;
              state <= S_FHEAD;
            end
          end
        end

        S_WALK: begin
          if (!rd_used && (rd_size >= need)) begin
            cur_size <= rd_size;
            state    <= S_SPLIT;
          end else if (rd_size == '0) begin
            res_status <= ffha_pkg::ST_CORRUPT;
            state      <= S_FIN;
          end else if (npos == heap_end) begin
            if (end_sum > {1'b0, lim}) begin
              res_status <= ffha_pkg::ST_NOROOM;
              state      <= S_FIN;
            end else begin
              // appended block fits exactly, so it is taken whole
              heap_end <= end_sum[PW-1:0];
              pos      <= npos;
              cur_size <= need;
              state    <= S_SPLIT;
            end
          end else if ((npos > heap_end) || (npos >= HEAP_W)) begin
            res_status <= ffha_pkg::ST_CORRUPT;
            state      <= S_FIN;
          end else begin
            pos <= npos;
          end
        end

        S_FHEAD: begin
          if (rd_size == '0) begin
            res_status <= ffha_pkg::ST_IGNORED;
            state      <= S_FIN;
          end else begin
            cur_size <= rd_size;
            nxt      <= npos;
            state    <= S_FMERGE;
          end
        end

        S_FMERGE: begin
          if (merge_ok) begin
            cur_size <= cur_size + rd_size;
            nxt      <= nxt_merge;
          end else begin
            res_status <= ffha_pkg::ST_OK;
            state      <= S_FIN;
          end
        end

        S_SPLIT: begin
          if (do_split) begin
            state <= S_MARK;
          end else begin
            res_offset <= grant_off[ffha_pkg::FIELD_W-1:0];
            res_status <= ffha_pkg::ST_OK;
            state      <= S_FIN;
          end
        end

        S_MARK: begin
          res_offset <= grant_off[ffha_pkg::FIELD_W-1:0];
          res_status <= ffha_pkg::ST_OK;
          state      <= S_FIN;
        end

        S_FIN: begin
          // hold the result until the output register frees up
          if (!out_valid || !out_stall) begin
            result_offset <= res_offset;
            status        <= res_status;
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/ffha_hdr_ram.sv =====
// ----------------------------------------------------------------------------
// ffha_hdr_ram
// Header store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffha_hdr_ram #(
  parameter int DEPTH = ffha_pkg::HEAP_BYTES_DEF,
  parameter int DW    = 15
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
